// ===== src/reod_pkg.sv =====
// Package of the RMS envelope onset detector: widths, register indexes,
// state encodings and the sample magnitude function.
// Used by reod_root and rms_envelope_onset_detector.
package reod_pkg;

  localparam int SAMPLE_BITS      = 16;
  localparam int FRAME_COUNT_BITS = 16;

  localparam int MEAN_BITS  = 2 * (SAMPLE_BITS - 1) + 1;
  localparam int SUM_BITS   = MEAN_BITS + FRAME_COUNT_BITS;
  localparam int ROOT_BITS  = SAMPLE_BITS;
  localparam int WORK_BITS  = MEAN_BITS + 1;
  localparam int SREM_BITS  = ROOT_BITS + 2;
  localparam int DIV_STEP_BITS = $clog2(MEAN_BITS);
  localparam int SQ_STEP_BITS  = $clog2(SAMPLE_BITS);

  localparam int RMS_BITS    = 16;
  localparam int TIME_BITS   = 32;
  localparam int PERIOD_BITS = 10;
  localparam int RISE_BITS   = 16;
  localparam int RISE_PROD_BITS = ROOT_BITS + RISE_BITS;
  localparam int CFG_DATA_BITS  = 16;
  localparam int CFG_INDEX_BITS = 2;

  localparam logic [ROOT_BITS-1:0] ONSET_LEVEL =
    ROOT_BITS'((3 << (SAMPLE_BITS - 1)) / 25);

  localparam logic [FRAME_COUNT_BITS-1:0] SPF_RESET    = FRAME_COUNT_BITS'(2205);
  localparam logic [PERIOD_BITS-1:0]      PERIOD_RESET = PERIOD_BITS'(50);
  localparam logic [RISE_BITS-1:0]        RISE_RESET   = RISE_BITS'(461);

  localparam logic [CFG_INDEX_BITS-1:0] CFG_SAMPLES_PER_FRAME = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_FRAME_PERIOD_MS   = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_RISE_MULTIPLIER   = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SQUARE = 4'b0010,
    ST_ROOT   = 4'b0100,
    ST_EMIT   = 4'b1000
  } state_e;

  typedef enum logic [2:0] {
    RS_IDLE = 3'b001,
    RS_DIV  = 3'b010,
    RS_SQRT = 3'b100
  } root_state_e;

  function automatic logic [SAMPLE_BITS-1:0] magnitude(input logic [SAMPLE_BITS-1:0] raw);
    logic [SAMPLE_BITS-1:0] neg;
    neg = ~raw + SAMPLE_BITS'(1);
    return raw[SAMPLE_BITS-1] ? neg : raw;
  endfunction

endpackage

// ===== src/reod_root.sv =====
// Serial mean and root unit: restoring division of the frame sum by the
// sample count, one quotient bit a cycle, then a two-bit-a-cycle square root.
// Depends on reod_pkg.
module reod_root (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic [reod_pkg::SUM_BITS-1:0]         sum_i,
  input  logic [reod_pkg::FRAME_COUNT_BITS-1:0] count_i,
  output logic                                 done_o,
  output logic [reod_pkg::ROOT_BITS-1:0]        root_o
);

  localparam int FCB = reod_pkg::FRAME_COUNT_BITS;
  localparam int WB  = reod_pkg::WORK_BITS;
  localparam int MB  = reod_pkg::MEAN_BITS;
  localparam int RB  = reod_pkg::ROOT_BITS;
  localparam int SB  = reod_pkg::SREM_BITS;
  localparam int STB = reod_pkg::DIV_STEP_BITS;

  reod_pkg::root_state_e state_q, state_d;
  logic [STB-1:0] step_q, step_d;
  logic [FCB-1:0] rem_q, rem_d;
  logic [FCB-1:0] den_q, den_d;
  logic [WB-1:0]  work_q, work_d;
  logic [SB-1:0]  srem_q, srem_d;
  logic [RB-1:0]  root_q, root_d;
  logic           done_q, done_d;

  logic [FCB:0]  div_trial;
  logic [FCB:0]  div_diff;
  logic          div_ge;
  logic [SB+1:0] sq_acc;
  logic [SB+1:0] sq_trial;
  logic [SB+1:0] sq_diff;
  logic          sq_ge;

  assign div_trial = {rem_q, work_q[MB-1]};
  assign div_diff  = div_trial - {1'b0, den_q};
  assign div_ge    = div_trial >= {1'b0, den_q};

  assign sq_acc   = {srem_q, work_q[WB-1:WB-2]};
  assign sq_trial = {2'b00, root_q, 2'b01};
  assign sq_diff  = sq_acc - sq_trial;
  assign sq_ge    = sq_acc >= sq_trial;

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    rem_d   = rem_q;
    den_d   = den_q;
    work_d  = work_q;
    srem_d  = srem_q;
    root_d  = root_q;
    done_d  = 1'b0;
    unique case (state_q)
      reod_pkg::RS_IDLE: begin
        if (start_i) begin
          rem_d   = sum_i[reod_pkg::SUM_BITS-1:MB];
          work_d  = {1'b0, sum_i[MB-1:0]};
          den_d   = count_i;
          step_d  = '0;
          state_d = reod_pkg::RS_DIV;
        end
      end
      reod_pkg::RS_DIV: begin
        rem_d  = div_ge ? div_diff[FCB-1:0] : div_trial[FCB-1:0];
        work_d = {1'b0, work_q[MB-2:0], div_ge};
        step_d = step_q + STB'(1);
        if (step_q == STB'(MB - 1)) begin
          step_d  = '0;
          srem_d  = '0;
          root_d  = '0;
          state_d = reod_pkg::RS_SQRT;
        end
      end
      reod_pkg::RS_SQRT: begin
        srem_d = sq_ge ? sq_diff[SB-1:0] : sq_acc[SB-1:0];
        root_d = {root_q[RB-2:0], sq_ge};
        work_d = {work_q[WB-3:0], 2'b00};
        step_d = step_q + STB'(1);
        if (step_q == STB'(RB - 1)) begin
          done_d  = 1'b1;
          state_d = reod_pkg::RS_IDLE;
        end
      end
      default: begin
        state_d = reod_pkg::RS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= reod_pkg::RS_IDLE;
      step_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    den_q  <= den_d;
    work_q <= work_d;
    srem_q <= srem_d;
    root_q <= root_d;
  end

  assign done_o = done_q;
  assign root_o = root_q;

`ifndef SYNTH
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == reod_pkg::RS_DIV |-> rem_q < den_q)
    else $error("division remainder not below divisor");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> state_q == reod_pkg::RS_IDLE)
    else $error("root done while unit busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && state_q != reod_pkg::RS_IDLE |-> 1'b0)
    else $error("root unit started while busy");
`endif

endmodule

// ===== src/rms_envelope_onset_detector.sv =====
// Frame RMS of a stereo stream with onset flag; top level, built on reod_pkg and reod_root.
// From accepting the closing sample to its result: serial square, root start, divide,
// root, done hand-over, then the output register.
// The input stalls while a sample is processed, so a new sample is taken only after the
// last one is through; a stalled output holds the block at frame end.
// Reset: asynchronous, active low; clears frame state and restores register defaults.
module rms_envelope_onset_detector (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [reod_pkg::SAMPLE_BITS-1:0] left_sample_i,
  input  logic signed [reod_pkg::SAMPLE_BITS-1:0] right_sample_i,
  input  logic                                right_present_i,
  input  logic                                stream_end_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [reod_pkg::RMS_BITS-1:0]        frame_rms_o,
  output logic                                onset_o,
  output logic [reod_pkg::TIME_BITS-1:0]       time_ms_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [reod_pkg::CFG_INDEX_BITS-1:0]  cfg_index_i,
  input  logic [reod_pkg::CFG_DATA_BITS-1:0]   cfg_data_i
);

  localparam int SB   = reod_pkg::SAMPLE_BITS;
  localparam int FCB  = reod_pkg::FRAME_COUNT_BITS;
  localparam int SUMB = reod_pkg::SUM_BITS;
  localparam int MB   = reod_pkg::MEAN_BITS;
  localparam int RB   = reod_pkg::ROOT_BITS;
  localparam int QB   = reod_pkg::SQ_STEP_BITS;
  localparam int PB   = reod_pkg::RISE_PROD_BITS;
  localparam int TB   = reod_pkg::TIME_BITS;

  localparam logic [RB-1:0] ONSET_LEVEL_EXT = reod_pkg::ONSET_LEVEL;

  reod_pkg::state_e state_q, state_d;

  logic [FCB-1:0]                    spf_q;
  logic [reod_pkg::PERIOD_BITS-1:0]  period_q;
  logic [reod_pkg::RISE_BITS-1:0]    rise_q;

  logic [SUMB-1:0] sum_q, sum_d;
  logic [FCB-1:0]  count_q, count_d;
  logic [RB-1:0]   prev_q, prev_d;
  logic [TB-1:0]   ftime_q, ftime_d;
  logic            last_q, last_d;
  logic [QB-1:0]   step_q, step_d;
  logic [MB-1:0]   mcand_q, mcand_d;
  logic [SB-1:0]   mplr_q, mplr_d;
  logic            start_q, start_d;
  logic [PB-1:0]   pmcand_q, pmcand_d;
  logic [reod_pkg::RISE_BITS-1:0] pmplr_q, pmplr_d;
  logic [PB-1:0]   prod_q, prod_d;

  logic                       out_valid_q, out_valid_d;
  logic [reod_pkg::RMS_BITS-1:0] out_rms_q, out_rms_d;
  logic                       out_onset_q, out_onset_d;
  logic [TB-1:0]              out_time_q, out_time_d;

  logic            in_accept;
  logic            out_free;
  logic [SB-1:0]   mag_l;
  logic [SB-1:0]   mag_r;
  logic [SB:0]     mag_sum;
  logic [FCB-1:0]  limit;
  logic            frame_close;
  logic            onset;
  logic            root_done;
  logic [RB-1:0]   root;

  reod_root u_root (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_q),
    .sum_i   (sum_q),
    .count_i (count_q),
    .done_o  (root_done),
    .root_o  (root)
  );

  assign in_stall_o  = state_q != reod_pkg::ST_IDLE;
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign cfg_ready_o = 1'b1;

  assign mag_l   = reod_pkg::magnitude(left_sample_i);
  assign mag_r   = right_present_i ? reod_pkg::magnitude(right_sample_i) : mag_l;
  assign mag_sum = {1'b0, mag_l} + {1'b0, mag_r};

  assign limit       = (spf_q == '0) ? FCB'(1) : spf_q;
  assign frame_close = last_q || (count_q >= limit);

  assign onset = (root > ONSET_LEVEL_EXT) && (root > prev_q) &&
                 ({{(PB-RB-8){1'b0}}, root, 8'h00} > prod_q);

  always_comb begin
    state_d     = state_q;
    sum_d       = sum_q;
    count_d     = count_q;
    prev_d      = prev_q;
    ftime_d     = ftime_q;
    last_d      = last_q;
    step_d      = step_q;
    mcand_d     = mcand_q;
    mplr_d      = mplr_q;
    start_d     = 1'b0;
    pmcand_d    = pmcand_q;
    pmplr_d     = pmplr_q;
    prod_d      = prod_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_rms_d   = out_rms_q;
    out_onset_d = out_onset_q;
    out_time_d  = out_time_q;
    unique case (state_q)
      reod_pkg::ST_IDLE: begin
        if (in_accept) begin
          mcand_d = MB'(mag_sum[SB:1]);
          mplr_d  = mag_sum[SB:1];
          last_d  = stream_end_i;
          count_d = count_q + FCB'(1);
          step_d  = '0;
          state_d = reod_pkg::ST_SQUARE;
        end
      end
      reod_pkg::ST_SQUARE: begin
        if (mplr_q[0]) begin
          sum_d = sum_q + SUMB'(mcand_q);
        end
        mcand_d = {mcand_q[MB-2:0], 1'b0};
        mplr_d  = {1'b0, mplr_q[SB-1:1]};
        step_d  = step_q + QB'(1);
        if (step_q == QB'(SB - 1)) begin
          if (frame_close) begin
            start_d  = 1'b1;
            pmcand_d = PB'(prev_q);
            pmplr_d  = rise_q;
            prod_d   = '0;
            state_d  = reod_pkg::ST_ROOT;
          end else begin
            state_d = reod_pkg::ST_IDLE;
          end
        end
      end
      reod_pkg::ST_ROOT: begin
        if (pmplr_q[0]) begin
          prod_d = prod_q + pmcand_q;
        end
        pmcand_d = {pmcand_q[PB-2:0], 1'b0};
        pmplr_d  = {1'b0, pmplr_q[reod_pkg::RISE_BITS-1:1]};
        if (root_done) begin
          state_d = reod_pkg::ST_EMIT;
        end
      end
      reod_pkg::ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_rms_d   = reod_pkg::RMS_BITS'(root);
          out_onset_d = onset;
          out_time_d  = ftime_q;
          sum_d       = '0;
          count_d     = '0;
          if (last_q) begin
            prev_d  = '0;
            ftime_d = '0;
          end else begin
            prev_d  = root;
            ftime_d = ftime_q + TB'(period_q);
          end
          state_d = reod_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = reod_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spf_q    <= reod_pkg::SPF_RESET;
      period_q <= reod_pkg::PERIOD_RESET;
      rise_q   <= reod_pkg::RISE_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        reod_pkg::CFG_SAMPLES_PER_FRAME: spf_q <= FCB'(cfg_data_i);
        reod_pkg::CFG_FRAME_PERIOD_MS: begin
          period_q <= cfg_data_i[reod_pkg::PERIOD_BITS-1:0];
        end
        reod_pkg::CFG_RISE_MULTIPLIER: rise_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= reod_pkg::ST_IDLE;
      sum_q       <= '0;
      count_q     <= '0;
      prev_q      <= '0;
      ftime_q     <= '0;
      last_q      <= 1'b0;
      step_q      <= '0;
      start_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sum_q       <= sum_d;
      count_q     <= count_d;
      prev_q      <= prev_d;
      ftime_q     <= ftime_d;
      last_q      <= last_d;
      step_q      <= step_d;
      start_q     <= start_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mcand_q     <= mcand_d;
    mplr_q      <= mplr_d;
    pmcand_q    <= pmcand_d;
    pmplr_q     <= pmplr_d;
    prod_q      <= prod_d;
    out_rms_q   <= out_rms_d;
    out_onset_q <= out_onset_d;
    out_time_q  <= out_time_d;
  end

  assign out_valid_o = out_valid_q;
  assign frame_rms_o = out_rms_q;
  assign onset_o     = out_onset_q;
  assign time_ms_o   = out_time_q;

`ifndef SYNTH
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == reod_pkg::ST_EMIT |-> pmplr_q == '0)
    else $error("rise product unfinished at frame end");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == reod_pkg::ST_EMIT))
    else $error("result raised outside frame end");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_q |-> $past(state_q == reod_pkg::ST_SQUARE) && state_q == reod_pkg::ST_ROOT)
    else $error("root started outside frame close");
`endif

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench of rms_envelope_onset_detector: a directed table, then random
// streams under four idle and stall patterns, each frame result checked against a local predictor.
// Depends on reod_pkg for port widths and register indexes.
module testbench;

  localparam int ONSET_FLOOR   = (3 * 32768) / 25;
  localparam int SETTLE_CYCLES = 120;
  localparam int CYCLE_LIMIT   = 500000;
  localparam int HOLD_CYCLES   = 400;
  localparam int SEGMENTS      = 16;
  localparam int SEG_ITEMS     = 25;

  localparam int SMP_W  = reod_pkg::SAMPLE_BITS;
  localparam int RMS_W  = reod_pkg::RMS_BITS;
  localparam int TIME_W = reod_pkg::TIME_BITS;
  localparam int IDX_W  = reod_pkg::CFG_INDEX_BITS;
  localparam int DATA_W = reod_pkg::CFG_DATA_BITS;
  localparam int CNT_W  = reod_pkg::FRAME_COUNT_BITS;
  localparam int PER_W  = reod_pkg::PERIOD_BITS;
  localparam int RISE_W = reod_pkg::RISE_BITS;

  typedef struct packed {
    logic signed [SMP_W-1:0] left;
    logic signed [SMP_W-1:0] right;
    logic                    present;
    logic                    last;
  } sample_t;

  typedef struct packed {
    logic [RMS_W-1:0]  rms;
    logic              onset;
    logic [TIME_W-1:0] stamp;
  } frame_t;

  typedef enum logic [1:0] {ROW_SAMPLE, ROW_WRITE} row_kind_e;

  typedef struct {
    row_kind_e           kind;
    sample_t             smp;
    logic [IDX_W-1:0]    index;
    logic [DATA_W-1:0]   data;
    bit                  typed;
    frame_t              want;
  } row_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                    in_valid_i      = 1'b0;
  logic                    in_stall_o;
  logic signed [SMP_W-1:0] left_sample_i   = '0;
  logic signed [SMP_W-1:0] right_sample_i  = '0;
  logic                    right_present_i = 1'b0;
  logic                    stream_end_i    = 1'b0;
  logic                    out_valid_o;
  logic                    out_stall_i     = 1'b0;
  logic [RMS_W-1:0]        frame_rms_o;
  logic                    onset_o;
  logic [TIME_W-1:0]       time_ms_o;
  logic                    cfg_valid_i     = 1'b0;
  logic                    cfg_ready_o;
  logic [IDX_W-1:0]        cfg_index_i     = '0;
  logic [DATA_W-1:0]       cfg_data_i      = '0;

  // predictor state and register copies
  logic [63:0]        sq_sum;
  logic [CNT_W-1:0]   frame_count;
  logic [RMS_W-1:0]   last_rms;
  logic [TIME_W-1:0]  stamp;
  logic [CNT_W-1:0]   frame_len;
  logic [PER_W-1:0]   period;
  logic [RISE_W-1:0]  rise;

  frame_t frames_due[$];
  frame_t head;
  row_t   rows[$];
  int     failures  = 0;
  int     idle_pct  = 0;
  int     stall_pct = 0;
  int     hold_left = 0;
  bit     hold_arm  = 1'b0;
  int     cycle_count = 0;

  rms_envelope_onset_detector u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .left_sample_i  (left_sample_i),
    .right_sample_i (right_sample_i),
    .right_present_i(right_present_i),
    .stream_end_i   (stream_end_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .frame_rms_o    (frame_rms_o),
    .onset_o        (onset_o),
    .time_ms_o      (time_ms_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("== FAIL ==");
    $finish;
  end

  function automatic row_t smp_row(int l, int r, bit p, bit e);
    row_t w;
    w.kind  = ROW_SAMPLE;
    w.smp   = '{left: SMP_W'(l), right: SMP_W'(r), present: p, last: e};
    w.index = '0;
    w.data  = '0;
    w.typed = 1'b0;
    w.want  = '0;
    return w;
  endfunction

  function automatic row_t typed_row(int l, int r, bit p, int rms, bit on);
    row_t w;
    w       = smp_row(l, r, p, 1'b1);
    w.typed = 1'b1;
    w.want  = '{rms: RMS_W'(rms), onset: on, stamp: '0};
    return w;
  endfunction

  function automatic row_t wr_row(logic [IDX_W-1:0] idx, int val);
    row_t w;
    w       = smp_row(0, 0, 1'b0, 1'b0);
    w.kind  = ROW_WRITE;
    w.index = idx;
    w.data  = DATA_W'(val);
    return w;
  endfunction

  task automatic add_row(input row_t w);
    rows = {rows, w};
  endtask

  function automatic int idle_run(int pct);
    int n;
    n = 0;
    while (n < 24 && $urandom_range(99) < pct) n++;
    return n;
  endfunction

  function automatic logic signed [SMP_W-1:0] draw_level(int amp);
    int r;
    r = $urandom_range(31);
    if (r == 0) return 16'sh8000;
    if (r == 1) return 16'sh7fff;
    if (r < 6) return SMP_W'($urandom);
    return SMP_W'($urandom_range(2 * amp) - amp);
  endfunction

  task automatic predict_frame(input sample_t s, output bit closes, output frame_t f);
    logic signed [16:0] wl, wr;
    logic [16:0] ml, mr, mono, cnt, lim;
    logic [63:0] mean, root, trial;
    wl   = s.left;
    wr   = s.present ? s.right : s.left;
    ml   = (wl < 0) ? -wl : wl;
    mr   = (wr < 0) ? -wr : wr;
    mono = (ml + mr) >> 1;
    sq_sum      = sq_sum + 64'(mono) * 64'(mono);
    frame_count = frame_count + 1'b1;
    cnt    = (frame_count == '0) ? 17'h10000 : {1'b0, frame_count};
    lim    = (frame_len == '0) ? 17'd1 : {1'b0, frame_len};
    closes = s.last || (cnt >= lim);
    f      = '0;
    if (closes) begin
      mean = sq_sum / 64'(cnt);
      root = '0;
      for (int b = 16; b >= 0; b--) begin
        trial = root | (64'd1 << b);
        if (trial * trial <= mean) root = trial;
      end
      f.rms   = root[RMS_W-1:0];
      f.onset = (root > ONSET_FLOOR) && (root > 64'(last_rms)) &&
                ((root << 8) > 64'(last_rms) * 64'(rise));
      f.stamp = stamp;
      if (s.last) begin
        last_rms = '0;
        stamp    = '0;
      end else begin
        last_rms = root[RMS_W-1:0];
        stamp    = stamp + TIME_W'(period);
      end
      sq_sum      = '0;
      frame_count = '0;
    end
  endtask

  task automatic offer(input sample_t s, input bit typed, input frame_t want);
    int     gap;
    bit     closes;
    frame_t f;
    gap = idle_run(idle_pct);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    left_sample_i   <= s.left;
    right_sample_i  <= s.right;
    right_present_i <= s.present;
    stream_end_i    <= s.last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_frame(s, closes, f);
    if (closes) frames_due = {frames_due, (typed ? want : f)};
  endtask

  // drain the block before touching a register
  task automatic write_reg(input logic [IDX_W-1:0] idx,
                           input logic [DATA_W-1:0] val);
    in_valid_i <= 1'b0;
    while (frames_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    case (idx)
      reod_pkg::CFG_SAMPLES_PER_FRAME: frame_len = val;
      reod_pkg::CFG_FRAME_PERIOD_MS:   period    = val[PER_W-1:0];
      reod_pkg::CFG_RISE_MULTIPLIER:   rise      = val;
      default: ;
    endcase
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (frames_due.size() == 0) begin
          $error("unexpected frame: frame_rms %0d onset %0d time_ms %0d",
                 frame_rms_o, onset_o, time_ms_o);
          failures++;
        end else begin
          head = frames_due.pop_front();
          if (frame_rms_o !== head.rms) begin
            $error("frame_rms: expected %0d, actual %0d", head.rms, frame_rms_o);
            failures++;
          end
          if (onset_o !== head.onset) begin
            $error("onset: expected %0d, actual %0d", head.onset, onset_o);
            failures++;
          end
          if (time_ms_o !== head.stamp) begin
            $error("time_ms: expected %0d, actual %0d", head.stamp, time_ms_o);
            failures++;
          end
        end
      end
      if (hold_arm) begin
        hold_arm  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      out_stall_i <= (hold_left > 0) || ($urandom_range(99) < stall_pct);
      if (hold_left > 0) hold_left--;
    end
  end

  initial begin
    sample_t s;
    int      amp;
    int      mode;
    sq_sum      = '0;
    frame_count = '0;
    last_rms    = '0;
    stamp       = '0;
    frame_len   = reod_pkg::SPF_RESET;
    period      = reod_pkg::PERIOD_RESET;
    rise        = reod_pkg::RISE_RESET;

    add_row(typed_row(0, 0, 1'b1, 0, 1'b0));
    add_row(typed_row(-32768, -32768, 1'b1, 32768, 1'b1));
    add_row(typed_row(32767, -1, 1'b0, 32767, 1'b1));
    add_row(typed_row(-32768, 32767, 1'b1, 32767, 1'b1));
    add_row(typed_row(100, -32768, 1'b0, 100, 1'b0));
    add_row(typed_row(0, -32768, 1'b1, 16384, 1'b1));
    add_row(wr_row(reod_pkg::CFG_SAMPLES_PER_FRAME, 0));
    add_row(wr_row(reod_pkg::CFG_RISE_MULTIPLIER, 0));
    add_row(smp_row(1000, -1000, 1'b1, 1'b0));
    add_row(smp_row(5000, 5000, 1'b1, 1'b0));
    add_row(smp_row(5000, -5000, 1'b1, 1'b0));
    add_row(wr_row(reod_pkg::CFG_FRAME_PERIOD_MS, 1000));
    add_row(smp_row(20000, -20000, 1'b1, 1'b0));
    add_row(wr_row(reod_pkg::CFG_FRAME_PERIOD_MS, 1));
    add_row(smp_row(300, 300, 1'b0, 1'b0));
    add_row(wr_row(reod_pkg::CFG_RISE_MULTIPLIER, 65535));
    add_row(wr_row(reod_pkg::CFG_SAMPLES_PER_FRAME, 4));
    add_row(smp_row(8000, 8000, 1'b1, 1'b0));
    add_row(smp_row(-8000, 8000, 1'b1, 1'b0));
    add_row(smp_row(12000, -3, 1'b1, 1'b0));
    add_row(wr_row(reod_pkg::CFG_SAMPLES_PER_FRAME, 2));
    add_row(smp_row(-1, 1, 1'b1, 1'b0));
    add_row(smp_row(32767, 32767, 1'b1, 1'b1));
    add_row(wr_row(reod_pkg::CFG_SAMPLES_PER_FRAME, 65535));
    add_row(smp_row(-32768, 0, 1'b0, 1'b0));
    add_row(smp_row(0, 0, 1'b1, 1'b1));

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_WRITE) write_reg(rows[i].index, rows[i].data);
      else offer(rows[i].smp, rows[i].typed, rows[i].want);
    end

    amp = 32767;
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      idle_pct  = 0;
      stall_pct = 0;
      case ($urandom_range(7))
        0:       write_reg(reod_pkg::CFG_SAMPLES_PER_FRAME, '0);
        1:       write_reg(reod_pkg::CFG_SAMPLES_PER_FRAME, 16'hffff);
        2:       write_reg(reod_pkg::CFG_SAMPLES_PER_FRAME, 16'd1);
        default: write_reg(reod_pkg::CFG_SAMPLES_PER_FRAME, DATA_W'($urandom_range(2, 12)));
      endcase
      if ($urandom_range(1) == 0)
        write_reg(reod_pkg::CFG_FRAME_PERIOD_MS, DATA_W'($urandom_range(1, 1000)));
      case ($urandom_range(5))
        0:       write_reg(reod_pkg::CFG_RISE_MULTIPLIER, '0);
        1:       write_reg(reod_pkg::CFG_RISE_MULTIPLIER, 16'hffff);
        default: write_reg(reod_pkg::CFG_RISE_MULTIPLIER, DATA_W'($urandom_range(128, 800)));
      endcase
      mode = seg % 4;
      idle_pct  = (mode == 1) ? 53 : (mode == 3) ? 16 : 0;
      stall_pct = (mode == 2) ? 53 : (mode == 3) ? 16 : 0;
      if (seg == 0) hold_arm = 1'b1;
      for (int n = 0; n < SEG_ITEMS; n++) begin
        if ($urandom_range(5) == 0) begin
          case ($urandom_range(2))
            0:       amp = $urandom_range(300);
            1:       amp = $urandom_range(4000, 32767);
            default: amp = 32767;
          endcase
        end
        s.left    = draw_level(amp);
        s.right   = draw_level(amp);
        s.present = ($urandom_range(3) != 0);
        s.last    = ($urandom_range(39) == 0);
        offer(s, 1'b0, '0);
      end
    end

    in_valid_i <= 1'b0;
    while (frames_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (failures == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
